// File: rtl/core/dmsp_pkg.sv
// ----------------------------------------------------------------------------
// dmsp_pkg - digit matrix stream parser package
// Types, codes and the signature table shared by the parser files.
// ----------------------------------------------------------------------------
package dmsp_pkg;

  // Left shift applied to the dimension high byte before it is ORed in.
  localparam int DIM_HIGH_SHIFT = 8;

  typedef enum logic [2:0] {
    PH_SIG  = 3'd0,
    PH_HDR  = 3'd1,
    PH_DIG  = 3'd2,
    PH_CHK  = 3'd3,
    PH_EOS  = 3'd4,
    PH_DONE = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ST_RUN    = 3'd0,
    ST_OK     = 3'd1,
    ST_BADSIG = 3'd2,
    ST_TRUNC  = 3'd3,
    ST_BADCHK = 3'd4,
    ST_TRAIL  = 3'd5
  } status_t;

  // Header byte slots, in stream order.
  localparam logic [2:0] HDR_BASE    = 3'd0;
  localparam logic [2:0] HDR_DIM_LO  = 3'd1;
  localparam logic [2:0] HDR_DIM_HI  = 3'd2;
  localparam logic [2:0] HDR_ROWS    = 3'd3;
  localparam logic [2:0] HDR_PREC    = 3'd4;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic        digit_valid;
    logic [15:0] dim_index;
    logic [7:0]  prec_index;
    logic [7:0]  row_index;
    logic [7:0]  digit_value;
    logic [7:0]  base_value;
    logic [15:0] dimension_count;
    logic [7:0]  row_count;
    logic [7:0]  precision_count;
  } out_item_t;

  // Control from the parser to the digit cursor.
  typedef struct packed {
    logic clear;
    logic step;
  } cursor_ctrl_t;

  // Expected signature; positions past the text expect zero.
  function automatic logic [7:0] sig_byte(input logic [4:0] idx);
    logic [7:0] val;
    case (idx)
      5'd0:    val = 8'h48;
      5'd1:    val = 8'h49;
      5'd2:    val = 8'h6E;
      5'd3:    val = 8'h74;
      5'd4:    val = 8'h4C;
      5'd5:    val = 8'h69;
      5'd6:    val = 8'h62;
      5'd7:    val = 8'h20;
      5'd8:    val = 8'h47;
      5'd9:    val = 8'h65;
      5'd10:   val = 8'h6E;
      5'd11:   val = 8'h65;
      5'd12:   val = 8'h72;
      5'd13:   val = 8'h61;
      5'd14:   val = 8'h74;
      5'd15:   val = 8'h6F;
      5'd16:   val = 8'h72;
      5'd17:   val = 8'h4D;
      5'd18:   val = 8'h61;
      5'd19:   val = 8'h74;
      5'd20:   val = 8'h72;
      5'd21:   val = 8'h69;
      5'd22:   val = 8'h78;
      5'd23:   val = 8'h0A;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

// File: rtl/core/dmsp_stream_if.sv
// ----------------------------------------------------------------------------
// dmsp_stream_if - valid/ready stream channel
// Carries one payload per transaction; accepted when valid and ready are high.
// ----------------------------------------------------------------------------
interface dmsp_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/core/dmsp_digit_cursor.sv
// ----------------------------------------------------------------------------
// dmsp_digit_cursor - digit index counters and running check
// Walks row, then precision, then dimension, and folds digits into an XOR.
// ----------------------------------------------------------------------------
module dmsp_digit_cursor (
  input  logic                  clk,
  input  logic                  rst,
  input  dmsp_pkg::cursor_ctrl_t ctrl,
  input  logic [7:0]            digit,
  input  logic [15:0]           hdr_dimension,
  input  logic [7:0]            hdr_rows,
  input  logic [7:0]            hdr_precision,
  output logic [15:0]           cur_dim,
  output logic [7:0]            cur_prec,
  output logic [7:0]            cur_row,
  output logic [7:0]            xor_check,
  output logic                  last
);

  logic [15:0] dim_inc;
  logic [7:0]  prec_inc;
  logic [7:0]  row_inc;
  logic        row_wrap;
  logic        prec_wrap;
  logic        dim_wrap;

  assign row_inc   = cur_row + 8'd1;
  assign prec_inc  = cur_prec + 8'd1;
  assign dim_inc   = cur_dim + 16'd1;
  assign row_wrap  = (row_inc >= hdr_rows);
  assign prec_wrap = (prec_inc >= hdr_precision);
  assign dim_wrap  = (dim_inc >= hdr_dimension);
  assign last      = row_wrap && prec_wrap && dim_wrap;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      cur_dim   <= '0;
      cur_prec  <= '0;
      cur_row   <= '0;
      xor_check <= '0;
    end else if (ctrl.step) begin
      xor_check <= xor_check ^ digit;
      if (!row_wrap) begin
        cur_row <= row_inc;
      end else begin
        cur_row <= '0;
        if (!prec_wrap) begin
          cur_prec <= prec_inc;
        end else begin
          cur_prec <= '0;
          cur_dim  <= dim_wrap ? 16'd0 : dim_inc;
        end
      end
    end
  end

endmodule

// File: rtl/core/digit_matrix_stream_parser.sv
// ----------------------------------------------------------------------------
// digit_matrix_stream_parser - signature, header and digit stream parser
// Checks the signature, reads the header, reports each matrix digit.
// ----------------------------------------------------------------------------
// Takes one byte (or an end-of-stream mark) per transaction and returns one
// result per transaction, in order. A byte is registered on entry and its
// result is computed and registered in the result register, so a new byte can
// be taken every clock: the rate is one byte per cycle, limited only by the
// result channel's ready. The stream is a SIGNATURE_LENGTH-byte signature,
// five header bytes (base, dimension low, dimension high, rows m,
// precision), dimension*precision*m digits with the row index running
// fastest, one XOR check byte and then end of stream. Status is sticky once
// it leaves running; afterwards input is consumed with no further effect.
// There is no configuration port and no startup delay after reset.
module digit_matrix_stream_parser #(
  parameter int SIGNATURE_LENGTH = 24
) (
  input  logic          clk,
  input  logic          rst,
  dmsp_stream_if.sink   byte_in,
  dmsp_stream_if.source result
);

  localparam int SIG_POS_W  = (SIGNATURE_LENGTH > 1) ? $clog2(SIGNATURE_LENGTH) : 1;
  localparam int BYTE_POS_W = (SIG_POS_W > 3) ? SIG_POS_W : 3;

  // Input register
  logic                in_valid;
  dmsp_pkg::in_item_t  in_item;
  logic                fire;

  // Result register
  logic                res_valid;
  dmsp_pkg::out_item_t res_item;
  dmsp_pkg::out_item_t res_item_next;

  // Parser state
  dmsp_pkg::phase_t        phase, phase_next;
  dmsp_pkg::status_t       error_code, error_code_next;
  logic [BYTE_POS_W-1:0]   byte_position, byte_position_next;
  logic                    sig_mismatch, sig_mismatch_next;
  logic [7:0]              hdr_base, hdr_base_next;
  logic [15:0]             hdr_dimension, hdr_dimension_next;
  logic [7:0]              hdr_rows, hdr_rows_next;
  logic [7:0]              hdr_precision, hdr_precision_next;

  dmsp_pkg::cursor_ctrl_t  cursor_ctrl;
  logic [15:0]             cur_dim;
  logic [7:0]              cur_prec;
  logic [7:0]              cur_row;
  logic [7:0]              xor_check;
  logic                    cursor_last;

  logic                    at_end;
  logic [7:0]              b;
  logic                    active;
  logic                    sig_diff;
  logic                    sig_last;

  assign fire          = in_valid && (!res_valid || result.ready);
  assign byte_in.ready = !in_valid || fire;
  assign result.valid  = res_valid;
  assign result.payload = res_item;

  assign at_end   = in_item.action;
  assign b        = in_item.data_byte;
  assign active   = (error_code == dmsp_pkg::ST_RUN) && (phase != dmsp_pkg::PH_DONE);
  assign sig_diff = (b != dmsp_pkg::sig_byte(5'(byte_position)));
  assign sig_last = (byte_position == BYTE_POS_W'(SIGNATURE_LENGTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (byte_in.ready) begin
      in_valid <= byte_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) begin
      in_item <= byte_in.payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_item <= res_item_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= dmsp_pkg::PH_SIG;
      error_code    <= dmsp_pkg::ST_RUN;
      byte_position <= '0;
      sig_mismatch  <= 1'b0;
      hdr_base      <= '0;
      hdr_dimension <= '0;
      hdr_rows      <= '0;
      hdr_precision <= '0;
    end else if (fire) begin
      phase         <= phase_next;
      error_code    <= error_code_next;
      byte_position <= byte_position_next;
      sig_mismatch  <= sig_mismatch_next;
      hdr_base      <= hdr_base_next;
      hdr_dimension <= hdr_dimension_next;
      hdr_rows      <= hdr_rows_next;
      hdr_precision <= hdr_precision_next;
    end
  end

  // Next state
  always_comb begin
    phase_next         = phase;
    error_code_next    = error_code;
    byte_position_next = byte_position;
    sig_mismatch_next  = sig_mismatch;
    hdr_base_next      = hdr_base;
    hdr_dimension_next = hdr_dimension;
    hdr_rows_next      = hdr_rows;
    hdr_precision_next = hdr_precision;
    cursor_ctrl        = '0;
    if (fire && active) begin
      if (at_end && phase != dmsp_pkg::PH_EOS) begin
        error_code_next = dmsp_pkg::ST_TRUNC;
      end else begin
        unique case (phase)
          dmsp_pkg::PH_SIG: begin
            sig_mismatch_next = sig_mismatch || sig_diff;
            if (sig_last) begin
              byte_position_next = '0;
              if (sig_mismatch || sig_diff) begin
                error_code_next = dmsp_pkg::ST_BADSIG;
              end else begin
                phase_next = dmsp_pkg::PH_HDR;
              end
            end else begin
              byte_position_next = byte_position + BYTE_POS_W'(1);
            end
          end
          dmsp_pkg::PH_HDR: begin
            unique case (byte_position)
              BYTE_POS_W'(dmsp_pkg::HDR_BASE):   hdr_base_next = b;
              BYTE_POS_W'(dmsp_pkg::HDR_DIM_LO): hdr_dimension_next = {8'h00, b};
              BYTE_POS_W'(dmsp_pkg::HDR_DIM_HI): begin
                hdr_dimension_next = hdr_dimension |
                                     (16'(b) << dmsp_pkg::DIM_HIGH_SHIFT);
              end
              BYTE_POS_W'(dmsp_pkg::HDR_ROWS):   hdr_rows_next = b;
              default:                           hdr_precision_next = b;
            endcase
            if (byte_position >= BYTE_POS_W'(dmsp_pkg::HDR_PREC)) begin
              byte_position_next = '0;
              cursor_ctrl.clear  = 1'b1;
              // empty matrix goes straight to the check byte
              if (hdr_dimension == 16'd0 || b == 8'd0 || hdr_rows == 8'd0) begin
                phase_next = dmsp_pkg::PH_CHK;
              end else begin
                phase_next = dmsp_pkg::PH_DIG;
              end
            end else begin
              byte_position_next = byte_position + BYTE_POS_W'(1);
            end
          end
          dmsp_pkg::PH_DIG: begin
            cursor_ctrl.step = 1'b1;
            if (cursor_last) begin
              phase_next = dmsp_pkg::PH_CHK;
            end
          end
          dmsp_pkg::PH_CHK: begin
            if (b != xor_check) begin
              error_code_next = dmsp_pkg::ST_BADCHK;
            end else begin
              phase_next = dmsp_pkg::PH_EOS;
            end
          end
          dmsp_pkg::PH_EOS: begin
            if (at_end) begin
              phase_next = dmsp_pkg::PH_DONE;
            end else begin
              error_code_next = dmsp_pkg::ST_TRAIL;
            end
          end
          default: phase_next = dmsp_pkg::PH_DONE;
        endcase
      end
    end
  end

  // Result fields
  always_comb begin
    res_item_next = '0;
    if (error_code_next != dmsp_pkg::ST_RUN) begin
      res_item_next.status = error_code_next;
    end else if (phase_next == dmsp_pkg::PH_DONE) begin
      res_item_next.status = dmsp_pkg::ST_OK;
    end else begin
      res_item_next.status = dmsp_pkg::ST_RUN;
    end
    if (cursor_ctrl.step) begin
      res_item_next.digit_valid = 1'b1;
      res_item_next.dim_index   = cur_dim;
      res_item_next.prec_index  = cur_prec;
      res_item_next.row_index   = cur_row;
      res_item_next.digit_value = b;
    end
    res_item_next.base_value      = hdr_base_next;
    res_item_next.dimension_count = hdr_dimension_next;
    res_item_next.row_count       = hdr_rows_next;
    res_item_next.precision_count = hdr_precision_next;
  end

  dmsp_digit_cursor u_cursor (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (cursor_ctrl),
    .digit         (b),
    .hdr_dimension (hdr_dimension),
    .hdr_rows      (hdr_rows),
    .hdr_precision (hdr_precision),
    .cur_dim       (cur_dim),
    .cur_prec      (cur_prec),
    .cur_row       (cur_row),
    .xor_check     (xor_check),
    .last          (cursor_last)
  );

endmodule

// File: tb/digit_matrix_stream_parser_test.sv
// ----------------------------------------------------------------------------
// digit_matrix_stream_parser_test - self-checking bench for the stream parser
// Sends one signed stream (signature, header, digits, check, end mark). The
// way the stream is built or broken is drawn at random. A local copy of the
// parser predicts every result, and each returned transaction is compared
// field by field. Both channels idle at random.
// ----------------------------------------------------------------------------
module digit_matrix_stream_parser_test;

  localparam int SIGNATURE_LENGTH = 24;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEM_TARGET = 1950;
  localparam logic [191:0] SIG_TEXT =
    192'h48496E744C696220_47656E657261746F_724D61747269780A;

  // How the one stream of this run is shaped or broken.
  typedef enum int {
    PLAN_ACCEPT,
    PLAN_BAD_CHECK,
    PLAN_TRAILING,
    PLAN_CUT_DIGITS,
    PLAN_EMPTY,
    PLAN_CUT_CHECK,
    PLAN_BAD_SIG,
    PLAN_CUT_EARLY
  } stream_plan_t;

  logic clk;
  logic rst = 1'b1;

  dmsp_stream_if #(.payload_t(dmsp_pkg::in_item_t))  byte_ch ();
  dmsp_stream_if #(.payload_t(dmsp_pkg::out_item_t)) result_ch ();

  digit_matrix_stream_parser i_dut (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_ch),
    .result  (result_ch)
  );

  // Parser copy, in its post-reset state.
  dmsp_pkg::phase_t  stage         = dmsp_pkg::PH_SIG;
  dmsp_pkg::status_t verdict       = dmsp_pkg::ST_RUN;
  logic [4:0]        field_pos     = '0;
  logic              signature_bad = 1'b0;
  logic [7:0]        base_seen     = '0;
  logic [15:0]       dim_seen      = '0;
  logic [7:0]        rows_seen     = '0;
  logic [7:0]        prec_seen     = '0;
  logic [15:0]       at_dim        = '0;
  logic [7:0]        at_prec       = '0;
  logic [7:0]        at_row        = '0;
  logic [7:0]        digit_parity  = '0;

  dmsp_pkg::out_item_t pending_parse_results[$];
  int        mismatches = 0;
  int        results_seen = 0;
  int        quiet_cycles = 0;
  int        items_sent = 0;

  // Stimulus side
  stream_plan_t plan;
  int           cut_left = -1;
  logic         ended = 1'b0;
  logic         send_calm = 1'b0;
  logic [7:0]   shape_base;
  logic [15:0]  shape_dim;
  logic [7:0]   shape_rows;
  logic [7:0]   shape_prec;
  logic [7:0]   sent_parity;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [7:0] sig_expected(input logic [4:0] pos);
    if (int'(pos) < 24) return SIG_TEXT[191 - 8 * int'(pos) -: 8];
    return 8'h00;
  endfunction

  function automatic dmsp_pkg::out_item_t parse_stream_byte(input dmsp_pkg::in_item_t item);
    dmsp_pkg::out_item_t res;
    logic [7:0]          b;
    res = '0;
    b = item.data_byte;
    if (verdict == dmsp_pkg::ST_RUN && stage != dmsp_pkg::PH_DONE) begin
      if (item.action && stage != dmsp_pkg::PH_EOS) begin
        verdict = dmsp_pkg::ST_TRUNC;
      end else begin
        case (stage)
          dmsp_pkg::PH_SIG: begin
            if (b != sig_expected(field_pos)) signature_bad = 1'b1;
            if (int'(field_pos) + 1 >= SIGNATURE_LENGTH) begin
              field_pos = '0;
              if (signature_bad) verdict = dmsp_pkg::ST_BADSIG;
              else stage = dmsp_pkg::PH_HDR;
            end else begin
              field_pos = field_pos + 5'd1;
            end
          end
          dmsp_pkg::PH_HDR: begin
            case (field_pos[2:0])
              dmsp_pkg::HDR_BASE:   base_seen = b;
              dmsp_pkg::HDR_DIM_LO: dim_seen = {8'h00, b};
              dmsp_pkg::HDR_DIM_HI: begin
                dim_seen = dim_seen | (16'(b) << dmsp_pkg::DIM_HIGH_SHIFT);
              end
              dmsp_pkg::HDR_ROWS:   rows_seen = b;
              default:              prec_seen = b;
            endcase
            if (field_pos[2:0] >= dmsp_pkg::HDR_PREC) begin
              field_pos = '0;
              at_dim = '0;
              at_prec = '0;
              at_row = '0;
              digit_parity = '0;
              if (dim_seen == '0 || prec_seen == '0 || rows_seen == '0)
                stage = dmsp_pkg::PH_CHK;
              else stage = dmsp_pkg::PH_DIG;
            end else begin
              field_pos = field_pos + 5'd1;
            end
          end
          dmsp_pkg::PH_DIG: begin
            res.digit_valid = 1'b1;
            res.dim_index = at_dim;
            res.prec_index = at_prec;
            res.row_index = at_row;
            res.digit_value = b;
            digit_parity ^= b;
            // row runs fastest, then precision, then dimension
            at_row = at_row + 8'd1;
            if (at_row >= rows_seen) begin
              at_row = '0;
              at_prec = at_prec + 8'd1;
              if (at_prec >= prec_seen) begin
                at_prec = '0;
                at_dim = at_dim + 16'd1;
                if (at_dim >= dim_seen) begin
                  at_dim = '0;
                  stage = dmsp_pkg::PH_CHK;
                end
              end
            end
          end
          dmsp_pkg::PH_CHK: begin
            if (b != digit_parity) verdict = dmsp_pkg::ST_BADCHK;
            else stage = dmsp_pkg::PH_EOS;
          end
          dmsp_pkg::PH_EOS: begin
            if (item.action) stage = dmsp_pkg::PH_DONE;
            else verdict = dmsp_pkg::ST_TRAIL;
          end
          default: ;
        endcase
      end
    end
    if (verdict != dmsp_pkg::ST_RUN) res.status = verdict;
    else if (stage == dmsp_pkg::PH_DONE) res.status = dmsp_pkg::ST_OK;
    else res.status = dmsp_pkg::ST_RUN;
    res.base_value = base_seen;
    res.dimension_count = dim_seen;
    res.row_count = rows_seen;
    res.precision_count = prec_seen;
    return res;
  endfunction

  task automatic log_mismatch(input string what);
    mismatches++;
    $display("ERROR: %s", what);
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want)
      log_mismatch($sformatf("result %0d %s: expected %0h, got %0h",
                             results_seen, name, want, got));
  endtask

  // Predict on byte acceptance, check on result acceptance, in one process.
  always @(posedge clk) begin
    dmsp_pkg::out_item_t want;
    dmsp_pkg::out_item_t got;
    if (!rst) begin
      if (byte_ch.valid && byte_ch.ready)
        pending_parse_results.push_back(parse_stream_byte(byte_ch.payload));
      if (result_ch.valid && result_ch.ready) begin
        results_seen++;
        got = result_ch.payload;
        if (pending_parse_results.size() == 0) begin
          log_mismatch($sformatf("result %0d arrived with nothing pending", results_seen));
        end else begin
          want = pending_parse_results.pop_front();
          compare_field("status", 16'(want.status), 16'(got.status));
          compare_field("digit_valid", 16'(want.digit_valid), 16'(got.digit_valid));
          compare_field("dim_index", want.dim_index, got.dim_index);
          compare_field("prec_index", 16'(want.prec_index), 16'(got.prec_index));
          compare_field("row_index", 16'(want.row_index), 16'(got.row_index));
          compare_field("digit_value", 16'(want.digit_value), 16'(got.digit_value));
          compare_field("base_value", 16'(want.base_value), 16'(got.base_value));
          compare_field("dimension_count", want.dimension_count, got.dimension_count);
          compare_field("row_count", 16'(want.row_count), 16'(got.row_count));
          compare_field("precision_count", 16'(want.precision_count),
                        16'(got.precision_count));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("digit_matrix_stream_parser regression: fail");
        $finish;
      end
    end
  end

  // Result side back-pressure.
  initial begin
    int   stall;
    logic calm;
    result_ch.ready = 1'b0;
    calm = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) calm = !calm;
      stall = calm ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      @(negedge clk);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input logic action, input logic [7:0] data);
    int                 gap;
    dmsp_pkg::in_item_t item;
    if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item.action = action;
    item.data_byte = data;
    byte_ch.valid <= 1'b1;
    byte_ch.payload <= item;
    do @(posedge clk); while (!byte_ch.ready);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic logic stream_over();
    return ended || verdict != dmsp_pkg::ST_RUN;
  endfunction

  task automatic end_stream();
    send_item(1'b1, 8'($urandom_range(0, 255)));
    ended = 1'b1;
  endtask

  // One data byte of the stream, or the end mark once the cut point is hit.
  task automatic stream_byte(input logic [7:0] b);
    if (stream_over()) return;
    if (cut_left == 0) begin
      end_stream();
      return;
    end
    if (cut_left > 0) cut_left--;
    send_item(1'b0, b);
  endtask

  task automatic test_signature();
    int         bad_pos;
    logic [7:0] b;
    bad_pos = -1;
    if (plan == PLAN_BAD_SIG || (plan == PLAN_CUT_EARLY && $urandom_range(0, 1) == 1))
      bad_pos = $urandom_range(0, SIGNATURE_LENGTH - 1);
    for (int i = 0; i < SIGNATURE_LENGTH; i++) begin
      b = sig_expected(5'(i));
      if (i == bad_pos) b = b ^ 8'($urandom_range(1, 255));
      stream_byte(b);
    end
  endtask

  task automatic test_header();
    int target;
    if (stream_over()) return;
    shape_base = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                             : 8'($urandom_range(0, 255));
    case (plan)
      PLAN_CUT_DIGITS: begin
        // huge matrix, cut somewhere inside the digits
        shape_dim = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(256, 65535));
        shape_rows = $urandom_range(0, 1) ? 8'hFF : 8'($urandom_range(8, 255));
        shape_prec = $urandom_range(0, 1) ? 8'hFF : 8'($urandom_range(1, 255));
        cut_left = 5 + $urandom_range(1, 1900);
      end
      PLAN_EMPTY: begin
        shape_dim = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(1, 65535));
        shape_rows = $urandom_range(0, 1) ? 8'hFF : 8'($urandom_range(1, 255));
        shape_prec = $urandom_range(0, 1) ? 8'hFF : 8'($urandom_range(1, 255));
        case ($urandom_range(0, 2))
          0: shape_dim = '0;
          1: shape_rows = '0;
          default: shape_prec = '0;
        endcase
      end
      default: begin
        target = $urandom_range(1700, 1950);
        case ($urandom_range(0, 3))
          0: begin
            shape_rows = 8'd1;
            shape_prec = 8'd1;
          end
          1: begin
            case ($urandom_range(0, 2))
              0: shape_rows = 8'd1;
              1: shape_rows = 8'hFF;
              default: shape_rows = 8'($urandom_range(1, 255));
            endcase
            shape_prec = 8'd1;
          end
          2: begin
            shape_rows = 8'($urandom_range(1, 255));
            shape_prec = 8'($urandom_range(1, 8));
          end
          default: begin
            shape_rows = 8'($urandom_range(1, 4));
            shape_prec = 8'hFF;
          end
        endcase
        shape_dim = 16'(target / (int'(shape_rows) * int'(shape_prec)));
        if (shape_dim == '0) shape_dim = 16'd1;
        if (plan == PLAN_CUT_CHECK)
          cut_left = 5 + int'(shape_dim) * int'(shape_rows) * int'(shape_prec);
      end
    endcase
    stream_byte(shape_base);
    stream_byte(shape_dim[7:0]);
    stream_byte(shape_dim[15:8]);
    stream_byte(shape_rows);
    stream_byte(shape_prec);
  endtask

  task automatic test_digits();
    longint     total;
    logic [7:0] d;
    sent_parity = '0;
    if (stream_over()) return;
    total = longint'(shape_dim) * longint'(shape_rows) * longint'(shape_prec);
    for (longint n = 0; n < total && !stream_over(); n++) begin
      d = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                      : 8'($urandom_range(0, 255));
      stream_byte(d);
      sent_parity ^= d;
    end
  endtask

  task automatic test_check_byte();
    logic [7:0] chk;
    if (stream_over()) return;
    chk = sent_parity;
    if (plan == PLAN_BAD_CHECK || (plan == PLAN_EMPTY && $urandom_range(0, 3) == 0))
      chk ^= 8'($urandom_range(1, 255));
    stream_byte(chk);
  endtask

  task automatic test_end_of_stream();
    if (stream_over()) return;
    if (plan == PLAN_TRAILING) stream_byte(8'($urandom_range(0, 255)));
    else end_stream();
  endtask

  // Once the verdict is in, everything is consumed without effect; short
  // streams are topped up here to the usual run length.
  task automatic test_sticky_verdict();
    repeat (12) send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    while (items_sent < ITEM_TARGET)
      send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int pick;
    byte_ch.valid = 1'b0;
    byte_ch.payload = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    pick = $urandom_range(0, 99);
    if (pick < 35) plan = PLAN_ACCEPT;
    else if (pick < 50) plan = PLAN_BAD_CHECK;
    else if (pick < 62) plan = PLAN_TRAILING;
    else if (pick < 77) plan = PLAN_CUT_DIGITS;
    else if (pick < 84) plan = PLAN_EMPTY;
    else if (pick < 90) plan = PLAN_CUT_CHECK;
    else if (pick < 95) plan = PLAN_BAD_SIG;
    else plan = PLAN_CUT_EARLY;
    // early cut lands anywhere in signature or header
    if (plan == PLAN_CUT_EARLY) cut_left = $urandom_range(0, SIGNATURE_LENGTH + 4);

    test_signature();
    test_header();
    test_digits();
    test_check_byte();
    test_end_of_stream();
    test_sticky_verdict();
    byte_ch.valid <= 1'b0;

    while (pending_parse_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_parse_results.size() == 0) begin
      $display("digit_matrix_stream_parser regression: pass");
    end else begin
      $display("digit_matrix_stream_parser regression: fail");
    end
    $finish;
  end

endmodule
